>>> src/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants for the streaming KMP matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int BYTE_W          = 8;
	localparam int POS_W           = 32;
	localparam int CMD_W           = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

endpackage

>>> src/kmp_stream_matcher.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// Streaming Knuth-Morris-Pratt byte matcher with an incrementally built table.
// ----------------------------------------------------------------------------
// Input beats carry a command in s_tuser (clear, append pattern byte, text
// byte) and a byte in s_tdata. Every input beat yields exactly one output
// beat: m_tuser flags a completed match or a dropped append, m_tdata holds
// the start index of the match (zero otherwise).
// Pattern bytes and the prefix table live in two synchronous RAMs. One
// lookup step reads at the current length, compares and falls back. A
// text byte or an append is taken, then may walk back through up to the
// current matched or prefix length before it finishes; clear and unused
// commands finish without any fallback step.
// One item is in work at a time; the input is taken again as soon as the
// lookup loop has handed its result to the output register.
// While the output beat is stalled the block still accepts the next item
// and runs its lookup, holding it at the finish until the output frees.
// Reset empties the pattern and the search; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module kmp_stream_matcher #(
	parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] match_start
	output logic [1:0]  m_tuser    // [0] found, [1] overflow
);

	localparam int AW = $clog2(MAX_PATTERN);
	localparam int LW = AW + 1;
	localparam int BW = kmp_pkg::BYTE_W;
	localparam int PW = kmp_pkg::POS_W;

	typedef enum logic {ST_IDLE, ST_CHECK} state_t;

	state_t                    state_q;
	logic [kmp_pkg::CMD_W-1:0] cmd_q;
	logic [BW-1:0]             byte_q;
	logic                      loop_q;
	logic                      ovf_q;
	logic [AW-1:0]             k_q;
	logic [LW-1:0]             pat_len_q;
	logic [AW-1:0]             build_q;
	logic [AW-1:0]             matched_q;
	logic [PW-1:0]             pos_q;

	logic          out_valid_q;
	logic [PW-1:0] out_start_q;
	logic          out_found_q;
	logic          out_ovf_q;

	logic [BW-1:0] pat_rd;
	logic [AW-1:0] pre_rd;
	logic [AW-1:0] rd_k;
	logic [AW-1:0] start_k;
	logic [AW-1:0] nk;
	logic          accept;
	logic          out_free;
	logic          pat_match;
	logic          done;
	logic          finish;
	logic          full;
	logic [LW-1:0] j;
	logic          hit;
	logic          wr_en;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign full      = (pat_len_q == LW'(MAX_PATTERN));
	assign start_k   = (s_tuser == kmp_pkg::CMD_APPEND) ? build_q : matched_q;
	assign pat_match = (pat_rd == byte_q);
	assign done      = !loop_q || pat_match || (k_q == '0);
	assign nk        = (pre_rd < k_q) ? pre_rd : '0;
	assign finish    = (state_q == ST_CHECK) && done && out_free;
	assign j         = (loop_q && pat_match) ? (LW'(k_q) + LW'(1)) : '0;
	assign hit       = loop_q && (j == pat_len_q);
	assign wr_en     = finish && (cmd_q == kmp_pkg::CMD_APPEND) && !ovf_q;

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_k = start_k;
		end else if (!done) begin
			rd_k = nk;
		end else begin
			rd_k = k_q;
		end
	end

	kmp_ram #(.WIDTH(BW), .DEPTH(MAX_PATTERN)) u_pat_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pat_len_q[AW-1:0]),
		.wr_data (byte_q),
		.rd_addr (rd_k),
		.rd_data (pat_rd)
	);

	// prefix entry for length k sits at index k-1
	kmp_ram #(.WIDTH(AW), .DEPTH(MAX_PATTERN)) u_pre_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pat_len_q[AW-1:0]),
		.wr_data (j[AW-1:0]),
		.rd_addr (rd_k - AW'(1)),
		.rd_data (pre_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= kmp_pkg::CMD_CLEAR;
			byte_q      <= '0;
			loop_q      <= 1'b0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			pat_len_q   <= '0;
			build_q     <= '0;
			matched_q   <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			out_start_q <= '0;
			out_found_q <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !finish) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
						cmd_q   <= s_tuser;
						byte_q  <= s_tdata;
						k_q     <= start_k;
						ovf_q   <= (s_tuser == kmp_pkg::CMD_APPEND) && full;
						loop_q  <= (pat_len_q != '0) &&
							((s_tuser == kmp_pkg::CMD_TEXT) ||
							 ((s_tuser == kmp_pkg::CMD_APPEND) && !full));
					end
				end
				ST_CHECK: begin
					if (!done) begin
						k_q <= nk;
					end else if (out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_found_q <= (cmd_q == kmp_pkg::CMD_TEXT) && hit;
						out_ovf_q   <= ovf_q;
						out_start_q <= ((cmd_q == kmp_pkg::CMD_TEXT) && hit) ?
							(pos_q + PW'(1) - PW'(pat_len_q)) : '0;
						case (cmd_q)
							kmp_pkg::CMD_CLEAR: begin
								pat_len_q <= '0;
								build_q   <= '0;
								matched_q <= '0;
								pos_q     <= '0;
							end
							kmp_pkg::CMD_APPEND: begin
								matched_q <= '0;
								pos_q     <= '0;
								if (!ovf_q) begin
									build_q   <= j[AW-1:0];
									pat_len_q <= pat_len_q + LW'(1);
								end
							end
							kmp_pkg::CMD_TEXT: begin
								pos_q <= pos_q + PW'(1);
								if (hit) begin
									matched_q <= build_q;
								end else if (pat_len_q != '0) begin
									matched_q <= j[AW-1:0];
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_start_q;
	assign m_tuser  = {out_ovf_q, out_found_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		pat_len_q <= LW'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pat_len_q == '0) |-> (matched_q == '0 && build_q == '0))
		else $error("search state left over with empty pattern");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pat_len_q != '0) |-> (LW'(matched_q) < pat_len_q && LW'(build_q) < pat_len_q))
		else $error("match or prefix length not below pattern length");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && loop_q) |-> (LW'(k_q) < pat_len_q))
		else $error("lookup index outside loaded pattern");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_found_q && out_ovf_q))
		else $error("match and overflow flagged on one beat");

endmodule

>>> src/kmp_ram.sv
// ----------------------------------------------------------------------------
// kmp_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module kmp_ram #(
	parameter int WIDTH = kmp_pkg::BYTE_W,
	parameter int DEPTH = kmp_pkg::MAX_PATTERN_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
